// ----- hdl/ncrfe_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the request frame encoder.
// No dependencies; every other file of the encoder imports this package.
package ncrfe_pkg;

  localparam logic [15:0] CrcPoly    = 16'h8F57;
  localparam logic [7:0]  CharOffset = 8'h47;
  localparam logic [7:0]  FrameStart = 8'h23;
  localparam logic [7:0]  FrameEnd   = 8'h0D;
  localparam logic [7:0]  ReadCount  = 8'h10;
  localparam int unsigned PayMax     = 8;
  localparam int unsigned IdxW       = 3;

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE1 = 2'd1;
  localparam logic [1:0] OP_WRITE2 = 2'd2;
  localparam logic [1:0] OP_WRITE4 = 2'd3;

  // One classified request: the payload bytes in send order and the index of the last one.
  typedef struct packed {
    logic [PayMax-1:0][7:0] pay;
    logic [IdxW-1:0]        last_idx;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAY,
    ST_CRC,
    ST_END
  } back_state_e;

  // MSB-first CRC-16 update over one byte, no reflection.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] crc;
    logic        top;
    crc = crc_in;
    for (int i = 7; i >= 0; i--) begin
      top = crc[15] ^ b[i];
      crc = {crc[14:0], 1'b0};
      if (top) begin
        crc = crc ^ CrcPoly;
      end
    end
    return crc;
  endfunction

endpackage

// ----- hdl/ncrfe_front.sv -----
// Front end of the encoder: unpacks a request word and builds its payload bytes.
// Depends on ncrfe_pkg.
module ncrfe_front
  import ncrfe_pkg::*;
(
  input  logic [7:0]  device_address_i,
  input  logic [15:0] parameter_hash_i,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] write_data_i,
  output req_t        req_o
);

  always_comb begin
    req_o.pay      = '0;
    req_o.pay[0]   = device_address_i;
    req_o.pay[2]   = parameter_hash_i[15:8];
    req_o.pay[3]   = parameter_hash_i[7:0];
    case (opcode_i)
      OP_READ: begin
        req_o.pay[1]   = ReadCount;
        req_o.last_idx = IdxW'(3);
      end
      OP_WRITE1: begin
        req_o.pay[1]   = 8'h01;
        req_o.pay[4]   = write_data_i[7:0];
        req_o.last_idx = IdxW'(4);
      end
      OP_WRITE2: begin
        req_o.pay[1]   = 8'h02;
        req_o.pay[4]   = write_data_i[15:8];
        req_o.pay[5]   = write_data_i[7:0];
        req_o.last_idx = IdxW'(5);
      end
      OP_WRITE4: begin
        req_o.pay[1]   = 8'h04;
        req_o.pay[4]   = write_data_i[31:24];
        req_o.pay[5]   = write_data_i[23:16];
        req_o.pay[6]   = write_data_i[15:8];
        req_o.pay[7]   = write_data_i[7:0];
        req_o.last_idx = IdxW'(7);
      end
      default: begin
        req_o.pay[1]   = ReadCount;
        req_o.last_idx = IdxW'(3);
      end
    endcase
  end

endmodule

// ----- hdl/ncrfe_queue.sv -----
// Small register FIFO of classified requests between the front and back ends.
// Depends on ncrfe_pkg for the request type.
module ncrfe_queue
  import ncrfe_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output req_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  req_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/ncrfe_back.sv -----
// Back end of the encoder: walks one request, updates the CRC and emits the characters.
// Depends on ncrfe_pkg for the request type, the state enum and the CRC function.
module ncrfe_back
  import ncrfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  input  req_t       req_i,
  output logic       req_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  back_state_e     state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            hi_q, hi_d;
  logic [15:0]     crc_q, crc_d;
  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic            out_last_q;

  logic            can_load;
  logic            emit;
  logic [7:0]      emit_byte;
  logic            emit_last;
  logic [7:0]      cur_byte;
  logic [3:0]      nib;
  logic            at_last;

  assign can_load = !out_valid_q || out_ready_i;

  // Byte under coding in this state; nibble picked by the half flag.
  always_comb begin
    if (state_q == ST_CRC) begin
      cur_byte = idx_q[0] ? crc_q[7:0] : crc_q[15:8];
    end else begin
      cur_byte = req_i.pay[idx_q];
    end
    nib = hi_q ? cur_byte[7:4] : cur_byte[3:0];
  end

  assign at_last = (state_q == ST_PAY) ? (idx_q == req_i.last_idx) : idx_q[0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (req_valid_i && can_load) state_d = ST_PAY;
      ST_PAY:  if (can_load && !hi_q && at_last) state_d = ST_CRC;
      ST_CRC:  if (can_load && !hi_q && at_last) state_d = ST_END;
      ST_END:  if (can_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Character selection and counter updates.
  always_comb begin
    emit      = 1'b0;
    emit_byte = 8'h00;
    emit_last = 1'b0;
    req_pop_o = 1'b0;
    idx_d     = idx_q;
    hi_d      = hi_q;
    crc_d     = crc_q;
    case (state_q)
      ST_IDLE: begin
        emit      = req_valid_i;
        emit_byte = FrameStart;
        if (req_valid_i && can_load) begin
          idx_d = '0;
          hi_d  = 1'b1;
          crc_d = '0;
        end
      end
      ST_PAY, ST_CRC: begin
        emit      = 1'b1;
        emit_byte = {4'h0, nib} + CharOffset;
        if (can_load) begin
          hi_d = !hi_q;
          if (!hi_q) begin
            if (state_q == ST_PAY) begin
              crc_d = crc16_byte(crc_q, cur_byte);
            end
            idx_d = at_last ? '0 : idx_q + IdxW'(1);
          end
        end
      end
      ST_END: begin
        emit      = 1'b1;
        emit_byte = FrameEnd;
        emit_last = 1'b1;
        req_pop_o = can_load;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      hi_q        <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      hi_q    <= hi_d;
      if (can_load) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    if (can_load && emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- hdl/nibble_coded_request_frame_encoder.sv -----
// Top level of the request frame encoder: front end, request queue and back end.
// Depends on ncrfe_pkg, ncrfe_front, ncrfe_queue and ncrfe_back.
//
// Each request word on the slave stream becomes one frame on the master stream: the
// start character 0x23, the payload (address, count byte, hash high, hash low and
// 0, 1, 2 or 4 data bytes, most significant first) followed by its CRC-16 (polynomial
// 0x8F57, initial value 0, MSB first), each byte sent as two characters (high nibble
// plus 0x47, then low nibble plus 0x47), and the end character 0x0D flagged by tlast.
// Frames are 14, 16, 18 or 22 words long. The back end emits one word per cycle while
// the sink is ready, and frames follow each other without a gap. The front end classifies
// a request in the cycle it is accepted
// and parks it in a queue of QueueDepth entries, so new requests are taken while a
// frame is still going out, until the queue is full. The output word sits in a
// register, and the back end keeps producing while the sink takes words every cycle.
module nibble_coded_request_frame_encoder
  import ncrfe_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] device_address, [23:8] parameter_hash, [25:24] opcode, [57:26] write_data,
  // [63:58] zero fill
  input  logic [63:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] frame_byte
  output logic [7:0]  m_axis_tdata_o,
  // last_in_frame
  output logic        m_axis_tlast_o
);

  req_t front_req;
  req_t head_req;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic accept;

  assign s_axis_tready_o = !q_full;
  assign accept          = s_axis_tvalid_i && !q_full;

  ncrfe_front u_front (
    .device_address_i (s_axis_tdata_i[7:0]),
    .parameter_hash_i (s_axis_tdata_i[23:8]),
    .opcode_i         (s_axis_tdata_i[25:24]),
    .write_data_i     (s_axis_tdata_i[57:26]),
    .req_o            (front_req)
  );

  ncrfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (front_req),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head_req)
  );

  ncrfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (q_valid),
    .req_i       (head_req),
    .req_pop_o   (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the request frame encoder: random and directed requests in,
// every frame character compared against a frame built in the bench itself.
// Depends on ncrfe_pkg and nibble_coded_request_frame_encoder.
module tb;
  import ncrfe_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned CalmTail   = 40;

  typedef struct {
    logic [7:0]  addr;
    logic [15:0] hash;
    logic [1:0]  op;
    logic [31:0] data;
    bit          after_drain;  // hold this request back until every frame is out
  } request_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } frame_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tlast_o;

  request_t    request_q[$];
  frame_char_t awaited_chars[$];
  request_t    offered_req;
  int unsigned requests_taken = 0;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  nibble_coded_request_frame_encoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // CRC-16, MSB first: fold the whole byte into the top of the register, then shift.
  function automatic logic [15:0] crc_after_byte(logic [15:0] reg_in, logic [7:0] b);
    logic [15:0] acc;
    acc = reg_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      acc = acc[15] ? ((acc << 1) ^ CrcPoly) : (acc << 1);
    end
    return acc;
  endfunction

  // Builds the whole frame of one request and appends its characters to the
  // queue of characters still to come from the block.
  function automatic void encode_request(request_t r);
    logic [7:0]  body[$];
    logic [7:0]  count_byte;
    logic [15:0] crc;
    int          n;
    case (r.op)
      OP_READ:   n = 0;
      OP_WRITE1: n = 1;
      OP_WRITE2: n = 2;
      default:   n = 4;
    endcase
    count_byte = (r.op == OP_READ) ? ReadCount : 8'(n);
    body.push_back(r.addr);
    body.push_back(count_byte);
    body.push_back(r.hash[15:8]);
    body.push_back(r.hash[7:0]);
    for (int i = n - 1; i >= 0; i--) begin
      body.push_back(r.data[8*i +: 8]);
    end
    crc = '0;
    foreach (body[i]) begin
      crc = crc_after_byte(crc, body[i]);
    end
    body.push_back(crc[15:8]);
    body.push_back(crc[7:0]);
    awaited_chars.push_back('{FrameStart, 1'b0});
    foreach (body[i]) begin
      awaited_chars.push_back('{{4'h0, body[i][7:4]} + CharOffset, 1'b0});
      awaited_chars.push_back('{{4'h0, body[i][3:0]} + CharOffset, 1'b0});
    end
    awaited_chars.push_back('{FrameEnd, 1'b1});
  endfunction

  task automatic add_request(logic [7:0] addr, logic [15:0] hash, logic [1:0] op,
                             logic [31:0] data, bit after_drain);
    request_q.push_back('{addr, hash, op, data, after_drain});
  endtask

  task automatic note_fail(string what, frame_char_t exp_c, frame_char_t got_c);
    if (fail_cnt < 10) begin
      $display("mismatch (%s): expected %h last %b, got %h last %b", what, exp_c.ch,
               exp_c.last, got_c.ch, got_c.last);
    end
    fail_cnt++;
  endtask

  // Sender: offers the next pending request, idling in short random bursts until
  // the tail of the run.
  always @(posedge clk_i) begin
    logic        nv;
    logic [63:0] nd;
    bit          calm;
    if (rst_ni) begin
      nv = s_axis_tvalid_i;
      nd = s_axis_tdata_i;
      calm = request_q.size() < CalmTail;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        encode_request(offered_req);
        requests_taken <= requests_taken + 1;
        nv = 1'b0;
      end
      if (!nv && request_q.size() != 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_q[0].after_drain && awaited_chars.size() != 0) begin
          // Pause until the block has delivered everything it owes.
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 3);
        end else begin
          offered_req = request_q.pop_front();
          nv = 1'b1;
          nd = {6'b0, offered_req.data, offered_req.op, offered_req.hash, offered_req.addr};
        end
      end
      s_axis_tvalid_i <= nv;
      s_axis_tdata_i  <= nd;
    end
  end

  // One long receiver hold-off once the stream is well under way, so the request
  // queue inside the block fills up and tready drops.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && requests_taken >= 40) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Receiver: checks each accepted word against the oldest awaited character.
  always @(posedge clk_i) begin
    logic        nr;
    frame_char_t got_c;
    frame_char_t exp_c;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_c = '{m_axis_tdata_o, m_axis_tlast_o};
        if (awaited_chars.size() == 0) begin
          note_fail("unexpected word", '{8'h00, 1'b0}, got_c);
        end else begin
          exp_c = awaited_chars.pop_front();
          if (got_c.ch !== exp_c.ch || got_c.last !== exp_c.last) begin
            note_fail("frame word", exp_c, got_c);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        nr = 1'b0;
      end else if (hold_left > 0) begin
        nr = 1'b0;
      end else if (request_q.size() >= CalmTail && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(0, 3);
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
      m_axis_tready_i <= nr;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [31:0] d;
    // Directed: field extremes, every opcode, read with data present, short writes
    // with the unused high bytes set.
    add_request(8'h00, 16'h0000, OP_READ,   32'h0000_0000, 1'b0);
    add_request(8'hFF, 16'hFFFF, OP_READ,   32'hFFFF_FFFF, 1'b0);
    add_request(8'h80, 16'h00FF, OP_READ,   32'hDEAD_BEEF, 1'b0);
    add_request(8'h01, 16'h8000, OP_WRITE1, 32'h0000_00FF, 1'b0);
    add_request(8'h7F, 16'h7FFF, OP_WRITE1, 32'hFFFF_FF00, 1'b0);
    add_request(8'hA5, 16'h0001, OP_WRITE1, 32'h1234_5680, 1'b0);
    add_request(8'h3C, 16'hFF00, OP_WRITE2, 32'hA5A5_1234, 1'b0);
    add_request(8'hFE, 16'h0001, OP_WRITE2, 32'h0000_FFFF, 1'b0);
    add_request(8'h00, 16'hFFFF, OP_WRITE2, 32'hFFFF_0000, 1'b0);
    add_request(8'h00, 16'h0000, OP_WRITE4, 32'h0000_0000, 1'b0);
    add_request(8'hFF, 16'hFFFF, OP_WRITE4, 32'hFFFF_FFFF, 1'b0);
    add_request(8'h5A, 16'hC3C3, OP_WRITE4, 32'h8000_0001, 1'b0);
    add_request(8'h96, 16'h1234, OP_WRITE4, 32'h1234_5678, 1'b0);
    add_request(8'h69, 16'hABCD, OP_READ,   32'h0000_0001, 1'b0);
    // Random requests; a few wait for the block to drain completely first.
    for (int i = 0; i < 256; i++) begin
      case ($urandom_range(0, 7))
        0:       d = 32'h0000_0000;
        1:       d = 32'hFFFF_FFFF;
        default: d = $urandom;
      endcase
      add_request(8'($urandom), 16'($urandom), 2'($urandom), d, i == 0 || i == 150);
    end

    @(posedge rst_ni);
    while (request_q.size() != 0 || s_axis_tvalid_i || awaited_chars.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0 && awaited_chars.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

endmodule

// ----- filelist.f -----
hdl/ncrfe_pkg.sv
hdl/ncrfe_front.sv
hdl/ncrfe_queue.sv
hdl/ncrfe_back.sv
hdl/nibble_coded_request_frame_encoder.sv
tb/tb.sv
